// ===== hw/rtl/uri_component_splitter_defines.svh =====
// Assertion macros for the URI component splitter.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef URI_COMPONENT_SPLITTER_DEFINES_SVH
`define URI_COMPONENT_SPLITTER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define UCS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ucs assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define UCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ucs assertion failed");

`endif

// ===== hw/rtl/ucs_pkg.sv =====
// Shared types and constants for the URI component splitter.
// No dependencies; used by ucs_parser, ucs_emitter and the top level.
`timescale 1ns / 1ps

package ucs_pkg;

	localparam int NPARTS = 8;
	localparam int CODE_W = 3;
	localparam int BEG_W  = 10;
	localparam int LEN_W  = 11;
	localparam int PORT_W = 16;
	localparam int PROD_W = 20;

	localparam logic [PORT_W-1:0] PORT_MAX = 16'hFFFF;

	localparam logic [CODE_W-1:0] PT_SCHEME = 3'd0;
	localparam logic [CODE_W-1:0] PT_AUTH   = 3'd1;
	localparam logic [CODE_W-1:0] PT_USER   = 3'd2;
	localparam logic [CODE_W-1:0] PT_PASS   = 3'd3;
	localparam logic [CODE_W-1:0] PT_HOST   = 3'd4;
	localparam logic [CODE_W-1:0] PT_PATH   = 3'd5;
	localparam logic [CODE_W-1:0] PT_QUERY  = 3'd6;
	localparam logic [CODE_W-1:0] PT_FRAG   = 3'd7;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_RBRK  = 8'h5D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [3:0] {
		PH_SCHEME,
		PH_AFTER_COLON,
		PH_SLASH1,
		PH_H_START,
		PH_H_REG,
		PH_V6,
		PH_V6_END,
		PH_PORT,
		PH_PORT_DONE,
		PH_PATH,
		PH_QUERY,
		PH_FRAG
	} phase_t;

	// Finished split of one URI, handed from parser to emitter.
	typedef struct packed {
		logic [NPARTS-1:0][BEG_W-1:0] starts;
		logic [NPARTS-1:0][LEN_W-1:0] sizes;
		logic [NPARTS-1:0]            found;
		logic [PORT_W-1:0]            port;
		logic                         port_seen;
		logic                         overflow;
	} snap_t;

endpackage

// ===== hw/rtl/ucs_parser.sv =====
// Per-byte parse state of the URI component splitter.
// Depends on ucs_pkg; one byte is folded into the state on each step.
`timescale 1ns / 1ps

module ucs_parser #(
	parameter int MAX_LEN = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     in_byte,
	input  logic           in_last,
	output ucs_pkg::snap_t snap
);

	localparam int PW = $clog2(MAX_LEN + 1);
	localparam logic [PW-1:0] LIMIT = PW'(MAX_LEN);

	logic [PW-1:0]                                      pos_q, n_pos;
	ucs_pkg::phase_t                                    phase_q, n_phase;
	logic [ucs_pkg::NPARTS-1:0][ucs_pkg::BEG_W-1:0]     starts_q, n_starts;
	logic [ucs_pkg::NPARTS-1:0][ucs_pkg::LEN_W-1:0]     sizes_q, n_sizes;
	logic [ucs_pkg::NPARTS-1:0]                         found_q, n_found;
	logic [ucs_pkg::PORT_W-1:0]                         acc_q, n_acc;
	logic                                               seen_q, n_seen;
	logic                                               ovf_q, n_ovf;
	logic                                               ucolon_q, n_ucolon;
	logic                                               at_q, n_at;

	always_comb begin
		logic [ucs_pkg::BEG_W-1:0]  p10;
		logic [ucs_pkg::LEN_W-1:0]  p11;
		logic [ucs_pkg::BEG_W-1:0]  f10;
		logic [ucs_pkg::LEN_W-1:0]  f11;
		logic [ucs_pkg::PROD_W-1:0] prod;
		logic                       do_path;
		logic                       stop;
		logic                       sep;
		ucs_pkg::phase_t            path_ph;
		ucs_pkg::phase_t            work_ph;

		n_pos    = pos_q;
		n_phase  = phase_q;
		n_starts = starts_q;
		n_sizes  = sizes_q;
		n_found  = found_q;
		n_acc    = acc_q;
		n_seen   = seen_q;
		n_ovf    = ovf_q;
		n_ucolon = ucolon_q;
		n_at     = at_q;
		do_path  = 1'b0;
		stop     = 1'b0;
		path_ph  = ucs_pkg::PH_PATH;
		work_ph  = phase_q;
		p10      = ucs_pkg::BEG_W'(pos_q);
		p11      = ucs_pkg::LEN_W'(pos_q);
		sep      = (in_byte == ucs_pkg::CH_SLASH) || (in_byte == ucs_pkg::CH_QUEST) ||
			(in_byte == ucs_pkg::CH_HASH);
		prod     = (ucs_pkg::PROD_W'(acc_q) << 3) + (ucs_pkg::PROD_W'(acc_q) << 1) +
			ucs_pkg::PROD_W'(4'(in_byte - ucs_pkg::CH_ZERO));

		if (pos_q >= LIMIT) begin
			n_ovf = 1'b1;
		end else begin
			n_pos = pos_q + 1'b1;
			unique case (phase_q)
				ucs_pkg::PH_SCHEME: begin
					if (in_byte == ucs_pkg::CH_COLON) begin
						n_found[ucs_pkg::PT_SCHEME]  = 1'b1;
						n_starts[ucs_pkg::PT_SCHEME] = '0;
						n_sizes[ucs_pkg::PT_SCHEME]  = p11;
						n_phase = ucs_pkg::PH_AFTER_COLON;
					end else if (in_byte == ucs_pkg::CH_SLASH && pos_q == '0) begin
						n_phase = ucs_pkg::PH_SLASH1;
					end else if (sep) begin
						n_starts[ucs_pkg::PT_PATH] = '0;
						n_sizes[ucs_pkg::PT_PATH]  = p11;
						do_path = 1'b1;
					end
				end
				ucs_pkg::PH_AFTER_COLON: begin
					if (in_byte == ucs_pkg::CH_SLASH) begin
						n_phase = ucs_pkg::PH_SLASH1;
					end else begin
						n_starts[ucs_pkg::PT_PATH] = p10;
						n_sizes[ucs_pkg::PT_PATH]  = '0;
						do_path = 1'b1;
					end
				end
				ucs_pkg::PH_SLASH1: begin
					if (in_byte == ucs_pkg::CH_SLASH) begin
						n_found[ucs_pkg::PT_AUTH]  = 1'b1;
						n_found[ucs_pkg::PT_HOST]  = 1'b1;
						n_starts[ucs_pkg::PT_AUTH] = p10 + 1'b1;
						n_starts[ucs_pkg::PT_USER] = p10 + 1'b1;
						n_starts[ucs_pkg::PT_HOST] = p10 + 1'b1;
						n_phase = ucs_pkg::PH_H_START;
					end else begin
						n_starts[ucs_pkg::PT_PATH] = p10 - 1'b1;
						n_sizes[ucs_pkg::PT_PATH]  = ucs_pkg::LEN_W'(1);
						do_path = 1'b1;
					end
				end
				ucs_pkg::PH_PATH, ucs_pkg::PH_QUERY, ucs_pkg::PH_FRAG: begin
					do_path = 1'b1;
					path_ph = phase_q;
				end
				default: begin
					// authority: user info, host, port
					if (sep) begin
						n_starts[ucs_pkg::PT_PATH] = p10;
						n_sizes[ucs_pkg::PT_PATH]  = '0;
						do_path = 1'b1;
					end else begin
						n_sizes[ucs_pkg::PT_AUTH] = sizes_q[ucs_pkg::PT_AUTH] + 1'b1;
						if (!at_q) begin
							if (in_byte == ucs_pkg::CH_AT) begin
								n_at = 1'b1;
								n_found[ucs_pkg::PT_USER] = 1'b1;
								if (ucolon_q)
									n_found[ucs_pkg::PT_PASS] = 1'b1;
								n_starts[ucs_pkg::PT_HOST] = p10 + 1'b1;
								n_sizes[ucs_pkg::PT_HOST]  = '0;
								n_acc   = '0;
								n_seen  = 1'b0;
								n_phase = ucs_pkg::PH_H_START;
								stop    = 1'b1;
							end else if (ucolon_q) begin
								n_sizes[ucs_pkg::PT_PASS] = sizes_q[ucs_pkg::PT_PASS] + 1'b1;
							end else if (in_byte == ucs_pkg::CH_COLON) begin
								n_ucolon = 1'b1;
								n_starts[ucs_pkg::PT_PASS] = p10 + 1'b1;
							end else begin
								n_sizes[ucs_pkg::PT_USER] = sizes_q[ucs_pkg::PT_USER] + 1'b1;
							end
						end
						if (!stop && phase_q == ucs_pkg::PH_H_START) begin
							if (in_byte == ucs_pkg::CH_LBRK) begin
								n_starts[ucs_pkg::PT_HOST] = p10 + 1'b1;
								n_phase = ucs_pkg::PH_V6;
								stop    = 1'b1;
							end else begin
								n_starts[ucs_pkg::PT_HOST] = p10;
								work_ph = ucs_pkg::PH_H_REG;
								n_phase = ucs_pkg::PH_H_REG;
							end
						end
						if (!stop) begin
							unique case (work_ph)
								ucs_pkg::PH_H_REG: begin
									if (in_byte == ucs_pkg::CH_COLON)
										n_phase = ucs_pkg::PH_PORT;
									else
										n_sizes[ucs_pkg::PT_HOST] =
											n_sizes[ucs_pkg::PT_HOST] + 1'b1;
								end
								ucs_pkg::PH_V6: begin
									if (in_byte == ucs_pkg::CH_RBRK)
										n_phase = ucs_pkg::PH_V6_END;
									else
										n_sizes[ucs_pkg::PT_HOST] =
											n_sizes[ucs_pkg::PT_HOST] + 1'b1;
								end
								ucs_pkg::PH_V6_END: begin
									n_phase = (in_byte == ucs_pkg::CH_COLON) ?
										ucs_pkg::PH_PORT : ucs_pkg::PH_PORT_DONE;
								end
								ucs_pkg::PH_PORT: begin
									if (in_byte >= ucs_pkg::CH_ZERO &&
										in_byte <= ucs_pkg::CH_NINE) begin
										n_acc  = (prod > ucs_pkg::PROD_W'(ucs_pkg::PORT_MAX)) ?
											ucs_pkg::PORT_MAX : ucs_pkg::PORT_W'(prod);
										n_seen = 1'b1;
									end else begin
										n_phase = ucs_pkg::PH_PORT_DONE;
									end
								end
								default: ;
							endcase
						end
					end
				end
			endcase

			// path, query and fragment scanning
			if (do_path) begin
				n_phase = path_ph;
				unique case (path_ph)
					ucs_pkg::PH_PATH: begin
						if (in_byte == ucs_pkg::CH_QUEST) begin
							n_found[ucs_pkg::PT_QUERY]  = 1'b1;
							n_starts[ucs_pkg::PT_QUERY] = p10 + 1'b1;
							n_phase = ucs_pkg::PH_QUERY;
						end else if (in_byte == ucs_pkg::CH_HASH) begin
							n_found[ucs_pkg::PT_FRAG]  = 1'b1;
							n_starts[ucs_pkg::PT_FRAG] = p10 + 1'b1;
							n_phase = ucs_pkg::PH_FRAG;
						end else begin
							n_sizes[ucs_pkg::PT_PATH] = n_sizes[ucs_pkg::PT_PATH] + 1'b1;
						end
					end
					ucs_pkg::PH_QUERY: begin
						if (in_byte == ucs_pkg::CH_HASH) begin
							n_found[ucs_pkg::PT_FRAG]  = 1'b1;
							n_starts[ucs_pkg::PT_FRAG] = p10 + 1'b1;
							n_phase = ucs_pkg::PH_FRAG;
						end else begin
							n_sizes[ucs_pkg::PT_QUERY] = sizes_q[ucs_pkg::PT_QUERY] + 1'b1;
						end
					end
					default: begin
						n_sizes[ucs_pkg::PT_FRAG] = sizes_q[ucs_pkg::PT_FRAG] + 1'b1;
					end
				endcase
			end
		end

		// Close the path at end of text and assemble the record set.
		f10 = ucs_pkg::BEG_W'(n_pos);
		f11 = ucs_pkg::LEN_W'(n_pos);
		snap.starts    = n_starts;
		snap.sizes     = n_sizes;
		snap.found     = n_found;
		snap.port      = n_acc;
		snap.port_seen = n_seen;
		snap.overflow  = n_ovf;
		snap.found[ucs_pkg::PT_PATH] = 1'b1;
		unique case (n_phase)
			ucs_pkg::PH_SCHEME: begin
				snap.starts[ucs_pkg::PT_PATH] = '0;
				snap.sizes[ucs_pkg::PT_PATH]  = f11;
			end
			ucs_pkg::PH_SLASH1: begin
				snap.starts[ucs_pkg::PT_PATH] = f10 - 1'b1;
				snap.sizes[ucs_pkg::PT_PATH]  = ucs_pkg::LEN_W'(1);
			end
			ucs_pkg::PH_PATH, ucs_pkg::PH_QUERY, ucs_pkg::PH_FRAG: ;
			default: begin
				snap.starts[ucs_pkg::PT_PATH] = f10;
				snap.sizes[ucs_pkg::PT_PATH]  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= ucs_pkg::PH_SCHEME;
			starts_q <= '0;
			sizes_q  <= '0;
			found_q  <= '0;
			acc_q    <= '0;
			seen_q   <= 1'b0;
			ovf_q    <= 1'b0;
			ucolon_q <= 1'b0;
			at_q     <= 1'b0;
		end else if (step && in_last) begin
			pos_q    <= '0;
			phase_q  <= ucs_pkg::PH_SCHEME;
			starts_q <= '0;
			sizes_q  <= '0;
			found_q  <= '0;
			acc_q    <= '0;
			seen_q   <= 1'b0;
			ovf_q    <= 1'b0;
			ucolon_q <= 1'b0;
			at_q     <= 1'b0;
		end else if (step) begin
			pos_q    <= n_pos;
			phase_q  <= n_phase;
			starts_q <= n_starts;
			sizes_q  <= n_sizes;
			found_q  <= n_found;
			acc_q    <= n_acc;
			seen_q   <= n_seen;
			ovf_q    <= n_ovf;
			ucolon_q <= n_ucolon;
			at_q     <= n_at;
		end
	end

endmodule

// ===== hw/rtl/ucs_emitter.sv =====
// Result bank and record sequencer of the URI component splitter.
// Depends on ucs_pkg; holds one finished split and plays out its eight records.
`timescale 1ns / 1ps

module ucs_emitter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  ucs_pkg::snap_t              snap,
	output logic                        free,
	output logic                        part_valid,
	input  logic                        part_stall,
	output logic [ucs_pkg::CODE_W-1:0]  part_code,
	output logic                        part_present,
	output logic [ucs_pkg::BEG_W-1:0]   part_start,
	output logic [ucs_pkg::LEN_W-1:0]   part_length,
	output logic [ucs_pkg::PORT_W-1:0]  port_number,
	output logic                        port_present,
	output logic                        too_long,
	output logic                        last_part
);

	ucs_pkg::snap_t              bank_q;
	logic                        busy_q;
	logic [ucs_pkg::CODE_W-1:0]  idx_q;
	logic                        take;
	logic                        is_last;

	assign is_last = (idx_q == ucs_pkg::PT_FRAG);
	assign take    = busy_q && !part_stall;
	assign free    = !busy_q || (take && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			busy_q <= !is_last;
			idx_q  <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			bank_q <= snap;
	end

	always_comb begin
		part_valid   = busy_q;
		part_code    = idx_q;
		part_present = bank_q.found[idx_q];
		part_start   = part_present ? bank_q.starts[idx_q] : '0;
		part_length  = part_present ? bank_q.sizes[idx_q] : '0;
		port_present = bank_q.port_seen;
		port_number  = bank_q.port_seen ? bank_q.port : '0;
		too_long     = bank_q.overflow;
		last_part    = is_last;
	end

endmodule

// ===== hw/rtl/uri_component_splitter.sv =====
// Top level of the URI component splitter: input register, parser, emitter.
// Depends on ucs_pkg, ucs_parser, ucs_emitter and uri_component_splitter_defines.svh.
`timescale 1ns / 1ps
`include "uri_component_splitter_defines.svh"

// The block takes a URI one byte per transaction on the byte channel and, on
// the byte flagged in_last, produces eight part records (scheme, authority,
// user, password, host, path, query, fragment, in that order) on the part
// channel, each with offset, length, the saturated decimal port and the
// overflow flag. Throughput is one byte per clock unless a final byte is
// held: each byte passes an input register and updates the parse state in
// the same cycle. The finished split is copied into a one-deep result bank
// that plays out one record per cycle while part_stall is low. The next URI
// overlaps the drain; only a final byte arriving while the bank still holds
// records is held in the input register until the eighth record is taken.
// URIs of eight or more bytes run at full rate while part_stall is low;
// shorter ones wait. The first record follows the final byte through the
// input register and the bank. Bytes beyond MAX_LEN are dropped apart from
// their end marker and set too_long. No clearing pass follows reset.
module uri_component_splitter #(
	parameter int MAX_LEN = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// byte channel
	input  logic                        byte_valid,
	output logic                        byte_stall,
	input  logic [7:0]                  in_byte,
	input  logic                        in_last,
	// part channel
	output logic                        part_valid,
	input  logic                        part_stall,
	output logic [ucs_pkg::CODE_W-1:0]  part_code,
	output logic                        part_present,
	output logic [ucs_pkg::BEG_W-1:0]   part_start,
	output logic [ucs_pkg::LEN_W-1:0]   part_length,
	output logic [ucs_pkg::PORT_W-1:0]  port_number,
	output logic                        port_present,
	output logic                        too_long,
	output logic                        last_part
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           last_s1;
	logic           bank_free;
	logic           step;
	logic           load;
	ucs_pkg::snap_t snap;

	// Hold the registered byte only when it closes a URI and the bank is busy.
	assign byte_stall = valid_s1 && last_s1 && !bank_free;
	assign step       = valid_s1 && !byte_stall;
	assign load       = step && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!byte_stall)
			valid_s1 <= byte_valid;
	end

	// Capture payload on every accepted transaction.
	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	ucs_parser #(
		.MAX_LEN (MAX_LEN)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.snap    (snap)
	);

	ucs_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.snap         (snap),
		.free         (bank_free),
		.part_valid   (part_valid),
		.part_stall   (part_stall),
		.part_code    (part_code),
		.part_present (part_present),
		.part_start   (part_start),
		.part_length  (part_length),
		.port_number  (port_number),
		.port_present (port_present),
		.too_long     (too_long),
		.last_part    (last_part)
	);

	// Stall only ever holds a final byte.
	`UCS_ASSERT_NOW(a_stall_only_on_last, byte_stall, valid_s1 && last_s1)
	// A fresh record set always opens with the scheme record.
	`UCS_ASSERT_NEXT(a_set_starts_scheme, load, part_valid && part_code == ucs_pkg::PT_SCHEME)
	// Taking the final record with nothing loaded leaves the channel empty.
	`UCS_ASSERT_NEXT(a_drain_ends, part_valid && !part_stall && last_part && !load, !part_valid)
	// The path is reported on every record set.
	`UCS_ASSERT_NOW(a_path_present, part_valid && part_code == ucs_pkg::PT_PATH, part_present)

endmodule
